[rtl/smtp_pkg.sv]
`default_nettype none

package smtp_pkg;

   // one input item
   typedef struct packed {
      logic [2:0] cmd;
      logic [3:0] command_code;
      logic       params_ok;
      logic [7:0] payload_byte;
      logic       store_ok;
   } req_type;

   // one result item
   typedef struct packed {
      logic       reply_valid;
      logic [3:0] reply_code;
      logic       data_valid;
      logic [7:0] data_out;
      logic       body_done;
      logic       session_end;
      logic [1:0] end_status;
      logic [7:0] recipients;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/smtp_server_session_fsm.sv]
`default_nettype none

// SMTP server session controller.
// Input channel (req_valid/req_stall/req_item): one item per transfer - open,
// decoded command, mail body byte, store result or link error.
// Result channel (rsp_valid/rsp_stall/rsp_item): zero to three results per
// item; rsp_item.last marks the final result of an item.
// CSR port: APB-style, start_mode at 0x0, rcpt_limit at 0x4, pready tied high.
// Latency: with the result queue empty, an accepted item's first result is
// valid the cycle after the transfer. Throughput: one item per cycle while each gives at most one
// result and the receiver keeps up; a terminator mismatch releases up to
// three bytes, which drain one per cycle from the 4-entry result queue while the receiver keeps up.
// req_stall rises when more than one result is queued, so an item can be
// taken while a result waits but the queue never overflows.
// Reset (synchronous): session idle, matcher at start, recipient count zero,
// start_mode 0, rcpt_limit 100, result queue empty.
// When the receiver stalls, the head result holds; the input stalls once
// the queue backs up.
module smtp_server_session_fsm (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire smtp_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output smtp_pkg::rsp_type     rsp_item,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import smtp_pkg::*;

   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_CLEAR   = 8'b0000_0010,
      PH_GREETED = 8'b0000_0100,
      PH_MAIL    = 8'b0000_1000,
      PH_RCPT    = 8'b0001_0000,
      PH_DATA    = 8'b0010_0000,
      PH_STORE   = 8'b0100_0000,
      PH_ERROR   = 8'b1000_0000
   } phase_type;

   // terminator matcher: CR LF . CR LF
   typedef enum logic [4:0] {
      TP_START = 5'b00001,
      TP_CR    = 5'b00010,
      TP_CRLF  = 5'b00100,
      TP_DOT   = 5'b01000,
      TP_DOTCR = 5'b10000
   } term_type;

   localparam logic [2:0] KIND_OPEN  = 3'd0;
   localparam logic [2:0] KIND_CMD   = 3'd1;
   localparam logic [2:0] KIND_BYTE  = 3'd2;
   localparam logic [2:0] KIND_STORE = 3'd3;
   localparam logic [2:0] KIND_LINK  = 3'd4;

   localparam logic [3:0] CMD_EHLO = 4'd0;
   localparam logic [3:0] CMD_HELO = 4'd1;
   localparam logic [3:0] CMD_MAIL = 4'd2;
   localparam logic [3:0] CMD_RCPT = 4'd3;
   localparam logic [3:0] CMD_DATA = 4'd4;
   localparam logic [3:0] CMD_QUIT = 4'd5;
   localparam logic [3:0] CMD_RSET = 4'd6;
   localparam logic [3:0] CMD_NOOP = 4'd7;
   localparam logic [3:0] CMD_VRFY = 4'd8;

   localparam logic [3:0] RC_220 = 4'd0;
   localparam logic [3:0] RC_221 = 4'd1;
   localparam logic [3:0] RC_250 = 4'd2;
   localparam logic [3:0] RC_252 = 4'd3;
   localparam logic [3:0] RC_354 = 4'd4;
   localparam logic [3:0] RC_452 = 4'd5;
   localparam logic [3:0] RC_455 = 4'd6;
   localparam logic [3:0] RC_500 = 4'd7;
   localparam logic [3:0] RC_503 = 4'd8;
   localparam logic [3:0] RC_552 = 4'd9;

   localparam logic [1:0] END_MAIL = 2'd0;
   localparam logic [1:0] END_QUIT = 2'd1;
   localparam logic [1:0] END_ERR  = 2'd2;

   localparam logic [1:0] MODE_WELCOME = 2'd0;
   localparam logic [1:0] MODE_BROKEN  = 2'd1;

   localparam logic [2:0] ADDR_MODE  = 3'd0;
   localparam logic [2:0] ADDR_LIMIT = 3'd4;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_DOT = 8'h2E;

   phase_type  phase_ff, phase_in;
   term_type   term_ff, term_in;
   logic [7:0] rcpt_ff, rcpt_in;
   logic [1:0] start_mode_ff;
   logic [7:0] rcpt_limit_ff;

   // result queue
   rsp_type    queue_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   rsp_type    res [3];
   logic [1:0] res_n;
   logic       req_fire;
   logic       rsp_fire;
   logic       csr_write;

   function automatic rsp_type mk_reply(logic [3:0] rc);
      rsp_type r;
      r = '0;
      r.reply_valid = 1'b1;
      r.reply_code  = rc;
      return r;
   endfunction

   function automatic rsp_type mk_byte(logic [7:0] b);
      rsp_type r;
      r = '0;
      r.data_valid = 1'b1;
      r.data_out   = b;
      return r;
   endfunction

   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // ---------------------------------------------------------------------
   // session and matcher update for the item at the port
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      term_in  = term_ff;
      rcpt_in  = rcpt_ff;
      res_n    = 2'd0;
      for (int i = 0; i < 3; i++) begin
         res[i] = '0;
      end

      if (req_fire) begin
         case (req_item.cmd)
            KIND_OPEN: begin
               if (phase_ff == PH_IDLE) begin
                  rcpt_in = '0;
                  term_in = TP_START;
                  if (start_mode_ff == MODE_WELCOME) begin
                     phase_in = PH_CLEAR;
                     res[0]   = mk_reply(RC_220);
                     res_n    = 2'd1;
                  end else if (start_mode_ff == MODE_BROKEN) begin
                     phase_in = PH_ERROR;
                  end else begin
                     phase_in = PH_GREETED;
                  end
               end
            end
            KIND_CMD: begin
               if (phase_ff != PH_IDLE && phase_ff != PH_DATA &&
                   phase_ff != PH_STORE) begin
                  res_n = 2'd1;
                  case (req_item.command_code)
                     CMD_EHLO, CMD_HELO: begin
                        if (phase_ff != PH_CLEAR) begin
                           res[0] = mk_reply(RC_503);
                        end else if (!req_item.params_ok) begin
                           res[0] = mk_reply(RC_455);
                        end else begin
                           phase_in = PH_GREETED;
                           res[0]   = mk_reply(RC_250);
                        end
                     end
                     CMD_MAIL: begin
                        if (phase_ff == PH_ERROR) begin
                           res[0] = mk_reply(RC_552);
                        end else if (phase_ff != PH_GREETED) begin
                           res[0] = mk_reply(RC_503);
                        end else if (!req_item.params_ok) begin
                           res[0] = mk_reply(RC_455);
                        end else begin
                           phase_in = PH_MAIL;
                           res[0]   = mk_reply(RC_250);
                        end
                     end
                     CMD_RCPT: begin
                        if (phase_ff != PH_MAIL && phase_ff != PH_RCPT) begin
                           res[0] = mk_reply(RC_503);
                        end else if (!req_item.params_ok) begin
                           res[0] = mk_reply(RC_455);
                        end else if (rcpt_ff >= rcpt_limit_ff) begin
                           res[0] = mk_reply(RC_452);
                        end else begin
                           rcpt_in  = rcpt_ff + 8'd1;
                           phase_in = PH_RCPT;
                           res[0]   = mk_reply(RC_250);
                        end
                     end
                     CMD_DATA: begin
                        if (phase_ff != PH_RCPT) begin
                           res[0] = mk_reply(RC_503);
                        end else begin
                           phase_in = PH_DATA;
                           term_in  = TP_START;
                           res[0]   = mk_reply(RC_354);
                        end
                     end
                     CMD_QUIT: begin
                        phase_in              = PH_IDLE;
                        res[0]                = mk_reply(RC_221);
                        res[0].session_end    = 1'b1;
                        res[0].end_status     = END_QUIT;
                     end
                     CMD_RSET: begin
                        if (phase_ff == PH_MAIL || phase_ff == PH_RCPT) begin
                           rcpt_in  = '0;
                           phase_in = PH_GREETED;
                        end
                        res[0] = mk_reply(RC_250);
                     end
                     CMD_NOOP: res[0] = mk_reply(RC_250);
                     CMD_VRFY: res[0] = mk_reply(RC_252);
                     default:  res[0] = mk_reply(RC_500);
                  endcase
               end
            end
            KIND_BYTE: begin
               if (phase_ff == PH_DATA) begin
                  case (term_ff)
                     TP_CR: begin
                        res[0]  = mk_byte(req_item.payload_byte);
                        res_n   = 2'd1;
                        term_in = (req_item.payload_byte == CH_LF) ? TP_CRLF :
                                  (req_item.payload_byte == CH_CR) ? TP_CR : TP_START;
                     end
                     TP_CRLF: begin
                        if (req_item.payload_byte == CH_DOT) begin
                           term_in = TP_DOT;
                        end else begin
                           res[0]  = mk_byte(req_item.payload_byte);
                           res_n   = 2'd1;
                           term_in = (req_item.payload_byte == CH_CR) ? TP_CR : TP_START;
                        end
                     end
                     TP_DOT: begin
                        if (req_item.payload_byte == CH_CR) begin
                           term_in = TP_DOTCR;
                        end else begin
                           // release the held dot
                           res[0]  = mk_byte(CH_DOT);
                           res[1]  = mk_byte(req_item.payload_byte);
                           res_n   = 2'd2;
                           term_in = TP_START;
                        end
                     end
                     TP_DOTCR: begin
                        if (req_item.payload_byte == CH_LF) begin
                           res[0].body_done = 1'b1;
                           res_n            = 2'd1;
                           term_in          = TP_START;
                           phase_in         = PH_STORE;
                        end else begin
                           // release held dot and CR
                           res[0]  = mk_byte(CH_DOT);
                           res[1]  = mk_byte(CH_CR);
                           res[2]  = mk_byte(req_item.payload_byte);
                           res_n   = 2'd3;
                           term_in = (req_item.payload_byte == CH_CR) ? TP_CR : TP_START;
                        end
                     end
                     default: begin
                        res[0]  = mk_byte(req_item.payload_byte);
                        res_n   = 2'd1;
                        term_in = (req_item.payload_byte == CH_CR) ? TP_CR : TP_START;
                     end
                  endcase
               end
            end
            KIND_STORE: begin
               if (phase_ff == PH_STORE) begin
                  res_n = 2'd1;
                  if (req_item.store_ok) begin
                     phase_in           = PH_IDLE;
                     res[0]             = mk_reply(RC_250);
                     res[0].session_end = 1'b1;
                     res[0].end_status  = END_MAIL;
                  end else begin
                     phase_in = PH_RCPT;
                     res[0]   = mk_reply(RC_452);
                  end
               end
            end
            KIND_LINK: begin
               if (phase_ff != PH_IDLE) begin
                  phase_in           = PH_IDLE;
                  term_in            = TP_START;
                  res[0].session_end = 1'b1;
                  res[0].end_status  = END_ERR;
                  res_n              = 2'd1;
               end
            end
            default: ;
         endcase
      end

      // count after update, last flag on the final result
      for (int i = 0; i < 3; i++) begin
         res[i].recipients = rcpt_in;
         res[i].last       = (2'(i) == res_n - 2'd1);
      end
   end

   // ---------------------------------------------------------------------
   // result queue: up to three writes, one read per cycle
   // ---------------------------------------------------------------------
   assign wr_ptr_in = wr_ptr_ff + res_n;
   assign rd_ptr_in = rd_ptr_ff + 2'(rsp_fire);
   assign count_in  = count_ff + 3'(res_n) - 3'(rsp_fire);

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_item  = queue_ff[rd_ptr_ff];
   // room for a full three-result burst
   assign req_stall = (count_ff > 3'd1);

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < res_n) begin
            queue_ff[wr_ptr_ff + 2'(i)] <= res[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         term_ff   <= TP_START;
         rcpt_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         term_ff   <= term_in;
         rcpt_ff   <= rcpt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // ---------------------------------------------------------------------
   // CSR port
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         start_mode_ff <= MODE_WELCOME;
         rcpt_limit_ff <= 8'd100;
      end else if (csr_write) begin
         if (csr_paddr[2]) begin
            rcpt_limit_ff <= csr_pwdata[7:0];
         end else begin
            start_mode_ff <= csr_pwdata[1:0];
         end
      end
   end

   always_comb begin
      case ({csr_paddr[2], 2'b00})
         ADDR_MODE:  csr_prdata = {30'd0, start_mode_ff};
         ADDR_LIMIT: csr_prdata = {24'd0, rcpt_limit_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

endmodule

`default_nettype wire

[rtl/smtp_checker.sv]
`default_nettype none

module smtp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire smtp_pkg::rsp_type rsp_item
);
   import smtp_pkg::*;

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input only backs up behind queued results
   a_stall_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no queued result");

   // remaining results of an item follow without a gap
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_item.last |=> rsp_valid)
      else $error("result burst broken");

   // req_valid is part of the observed interface
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$isunknown(rsp_valid))
      else $error("result valid unknown after input transfer");

endmodule

bind smtp_server_session_fsm smtp_checker u_smtp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

[sim/smtp_session_checker.sv]
`default_nettype none

package smtp_tb_pkg;

   // item kinds on the request channel
   localparam logic [2:0] KIND_OPEN       = 3'd0;
   localparam logic [2:0] KIND_COMMAND    = 3'd1;
   localparam logic [2:0] KIND_BYTE       = 3'd2;
   localparam logic [2:0] KIND_STORE      = 3'd3;
   localparam logic [2:0] KIND_LINK_ERROR = 3'd4;

   // decoded SMTP commands
   localparam logic [3:0] CMD_EHLO    = 4'd0;
   localparam logic [3:0] CMD_HELO    = 4'd1;
   localparam logic [3:0] CMD_MAIL    = 4'd2;
   localparam logic [3:0] CMD_RCPT    = 4'd3;
   localparam logic [3:0] CMD_DATA    = 4'd4;
   localparam logic [3:0] CMD_QUIT    = 4'd5;
   localparam logic [3:0] CMD_RSET    = 4'd6;
   localparam logic [3:0] CMD_NOOP    = 4'd7;
   localparam logic [3:0] CMD_VRFY    = 4'd8;
   localparam logic [3:0] CMD_UNKNOWN = 4'd9;
   localparam logic [3:0] CMD_TOP     = 4'd15;

   // dense reply numbering
   localparam logic [3:0] RPL_NONE = 4'd0;
   localparam logic [3:0] RPL_220  = 4'd0;
   localparam logic [3:0] RPL_221  = 4'd1;
   localparam logic [3:0] RPL_250  = 4'd2;
   localparam logic [3:0] RPL_252  = 4'd3;
   localparam logic [3:0] RPL_354  = 4'd4;
   localparam logic [3:0] RPL_452  = 4'd5;
   localparam logic [3:0] RPL_455  = 4'd6;
   localparam logic [3:0] RPL_500  = 4'd7;
   localparam logic [3:0] RPL_503  = 4'd8;
   localparam logic [3:0] RPL_552  = 4'd9;

   localparam logic [1:0] END_NONE          = 2'd0;
   localparam logic [1:0] END_MAIL_ACCEPTED = 2'd0;
   localparam logic [1:0] END_CLIENT_QUIT   = 2'd1;
   localparam logic [1:0] END_RECEIVE_ERROR = 2'd2;

   localparam logic [1:0] MODE_WELCOME       = 2'd0;
   localparam logic [1:0] MODE_DYSFUNCTIONAL = 2'd1;
   localparam logic [1:0] MODE_GREETED       = 2'd2;

   localparam logic [2:0] CSR_START_MODE = 3'd0;
   localparam logic [2:0] CSR_RCPT_LIMIT = 3'd4;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_DOT = 8'h2E;

endpackage

module smtp_session_checker
   import smtp_pkg::*;
   import smtp_tb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_item,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_item,
   input  wire logic    csr_psel,
   input  wire logic    csr_penable,
   input  wire logic    csr_pwrite,
   input  wire logic    csr_pready,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic    end_of_run,
   output int           fail_count,
   output int           pending_results,
   output int           results_checked
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_CLEAR   = 3'd1;
   localparam logic [2:0] PH_GREETED = 3'd2;
   localparam logic [2:0] PH_MAIL    = 3'd3;
   localparam logic [2:0] PH_RCPT    = 3'd4;
   localparam logic [2:0] PH_DATA    = 3'd5;
   localparam logic [2:0] PH_STORE   = 3'd6;
   localparam logic [2:0] PH_ERROR   = 3'd7;

   localparam logic [2:0] MATCH_IDLE   = 3'd0;
   localparam logic [2:0] MATCH_CR     = 3'd1;
   localparam logic [2:0] MATCH_CRLF   = 3'd2;
   localparam logic [2:0] MATCH_DOT    = 3'd3;
   localparam logic [2:0] MATCH_DOT_CR = 3'd4;

   logic [2:0] session_state;
   logic [2:0] matcher_state;
   logic [7:0] rcpt_count;
   logic [1:0] mode_reg;
   logic [7:0] limit_reg;

   rsp_type session_results_q [$];
   rsp_type item_results [3];
   int      item_result_count;

   task automatic flag_mismatch(input string msg);
      if (fail_count < 40) $display("[%0t] MISMATCH %s", $time, msg);
      fail_count++;
   endtask

   function automatic void add_result(input logic rv, input logic [3:0] rc, input logic dv,
                                      input logic [7:0] d, input logic bd, input logic se,
                                      input logic [1:0] es);
      rsp_type r;
      r = '0;
      r.reply_valid = rv;
      r.reply_code  = rc;
      r.data_valid  = dv;
      r.data_out    = d;
      r.body_done   = bd;
      r.session_end = se;
      r.end_status  = es;
      r.recipients  = rcpt_count;
      item_results[item_result_count] = r;
      item_result_count++;
   endfunction

   function automatic void add_body_byte(input logic [7:0] d);
      add_result(1'b0, RPL_NONE, 1'b1, d, 1'b0, 1'b0, END_NONE);
   endfunction

   function automatic logic [3:0] answer_command(input logic [3:0] code, input logic ok,
                                                 output logic quit);
      quit = 1'b0;
      case (code)
         CMD_EHLO, CMD_HELO: begin
            if (session_state != PH_CLEAR) return RPL_503;
            if (!ok) return RPL_455;
            session_state = PH_GREETED;
            return RPL_250;
         end
         CMD_MAIL: begin
            if (session_state == PH_ERROR) return RPL_552;
            if (session_state != PH_GREETED) return RPL_503;
            if (!ok) return RPL_455;
            session_state = PH_MAIL;
            return RPL_250;
         end
         CMD_RCPT: begin
            if (session_state != PH_MAIL && session_state != PH_RCPT) return RPL_503;
            if (!ok) return RPL_455;
            if (rcpt_count >= limit_reg) return RPL_452;
            rcpt_count = rcpt_count + 8'd1;
            session_state = PH_RCPT;
            return RPL_250;
         end
         CMD_DATA: begin
            if (session_state != PH_RCPT) return RPL_503;
            session_state = PH_DATA;
            matcher_state = MATCH_IDLE;
            return RPL_354;
         end
         CMD_QUIT: begin
            quit = 1'b1;
            session_state = PH_IDLE;
            return RPL_221;
         end
         CMD_RSET: begin
            if (session_state == PH_MAIL || session_state == PH_RCPT) begin
               rcpt_count = '0;
               session_state = PH_GREETED;
            end
            return RPL_250;
         end
         CMD_NOOP: return RPL_250;
         CMD_VRFY: return RPL_252;
         default:  return RPL_500;
      endcase
   endfunction

   // held dot and CR come out again when the terminator match breaks
   function automatic void match_body_byte(input logic [7:0] c);
      case (matcher_state)
         MATCH_CR: begin
            add_body_byte(c);
            matcher_state = (c == CH_LF) ? MATCH_CRLF : (c == CH_CR) ? MATCH_CR : MATCH_IDLE;
         end
         MATCH_CRLF: begin
            if (c == CH_DOT) begin
               matcher_state = MATCH_DOT;
            end else begin
               add_body_byte(c);
               matcher_state = (c == CH_CR) ? MATCH_CR : MATCH_IDLE;
            end
         end
         MATCH_DOT: begin
            if (c == CH_CR) begin
               matcher_state = MATCH_DOT_CR;
            end else begin
               add_body_byte(CH_DOT);
               add_body_byte(c);
               matcher_state = MATCH_IDLE;
            end
         end
         MATCH_DOT_CR: begin
            if (c == CH_LF) begin
               add_result(1'b0, RPL_NONE, 1'b0, 8'h00, 1'b1, 1'b0, END_NONE);
               matcher_state = MATCH_IDLE;
               session_state = PH_STORE;
            end else begin
               add_body_byte(CH_DOT);
               add_body_byte(CH_CR);
               add_body_byte(c);
               matcher_state = (c == CH_CR) ? MATCH_CR : MATCH_IDLE;
            end
         end
         default: begin
            add_body_byte(c);
            matcher_state = (c == CH_CR) ? MATCH_CR : MATCH_IDLE;
         end
      endcase
   endfunction

   function automatic void predict_session_step(input req_type it);
      logic       quit;
      logic [3:0] code;
      item_result_count = 0;
      case (it.cmd)
         KIND_OPEN: begin
            if (session_state == PH_IDLE) begin
               rcpt_count = '0;
               matcher_state = MATCH_IDLE;
               if (mode_reg == MODE_WELCOME) begin
                  session_state = PH_CLEAR;
                  add_result(1'b1, RPL_220, 1'b0, 8'h00, 1'b0, 1'b0, END_NONE);
               end else if (mode_reg == MODE_DYSFUNCTIONAL) begin
                  session_state = PH_ERROR;
               end else begin
                  session_state = PH_GREETED;
               end
            end
         end
         KIND_COMMAND: begin
            if (session_state != PH_IDLE && session_state != PH_DATA &&
                session_state != PH_STORE) begin
               code = answer_command(it.command_code, it.params_ok, quit);
               add_result(1'b1, code, 1'b0, 8'h00, 1'b0, quit,
                          quit ? END_CLIENT_QUIT : END_NONE);
            end
         end
         KIND_BYTE: begin
            if (session_state == PH_DATA) match_body_byte(it.payload_byte);
         end
         KIND_STORE: begin
            if (session_state == PH_STORE) begin
               if (it.store_ok) begin
                  session_state = PH_IDLE;
                  add_result(1'b1, RPL_250, 1'b0, 8'h00, 1'b0, 1'b1, END_MAIL_ACCEPTED);
               end else begin
                  session_state = PH_RCPT;
                  add_result(1'b1, RPL_452, 1'b0, 8'h00, 1'b0, 1'b0, END_NONE);
               end
            end
         end
         KIND_LINK_ERROR: begin
            if (session_state != PH_IDLE) begin
               session_state = PH_IDLE;
               matcher_state = MATCH_IDLE;
               add_result(1'b0, RPL_NONE, 1'b0, 8'h00, 1'b0, 1'b1, END_RECEIVE_ERROR);
            end
         end
         default: ;
      endcase
      if (item_result_count > 0) item_results[item_result_count - 1].last = 1'b1;
      for (int i = 0; i < item_result_count; i++) session_results_q.push_back(item_results[i]);
   endfunction

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s: got %0h expected %0h", name, got, want));
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (session_results_q.size() == 0) begin
         flag_mismatch($sformatf("result %h with nothing expected", got));
         return;
      end
      want = session_results_q.pop_front();
      compare_field("reply_valid", 8'(got.reply_valid), 8'(want.reply_valid));
      compare_field("reply_code",  8'(got.reply_code),  8'(want.reply_code));
      compare_field("data_valid",  8'(got.data_valid),  8'(want.data_valid));
      compare_field("data_out",    got.data_out,        want.data_out);
      compare_field("body_done",   8'(got.body_done),   8'(want.body_done));
      compare_field("session_end", 8'(got.session_end), 8'(want.session_end));
      compare_field("end_status",  8'(got.end_status),  8'(want.end_status));
      compare_field("recipients",  got.recipients,      want.recipients);
      compare_field("last",        8'(got.last),        8'(want.last));
   endtask

   // result transfers are matched before the request transfer of the same edge:
   // a request's results never leave in the cycle it is taken
   always @(posedge clock) begin
      if (reset) begin
         session_state   = PH_IDLE;
         matcher_state   = MATCH_IDLE;
         rcpt_count      = '0;
         mode_reg        = MODE_WELCOME;
         limit_reg       = 8'd100;
         session_results_q.delete();
         fail_count      = 0;
         results_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_item);
            results_checked++;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               CSR_START_MODE: mode_reg = csr_pwdata[1:0];
               CSR_RCPT_LIMIT: limit_reg = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_session_step(req_item);
         if (end_of_run) begin
            while (session_results_q.size() > 0) begin
               flag_mismatch($sformatf("expected result %h never arrived",
                                       session_results_q.pop_front()));
            end
         end
      end
      pending_results = session_results_q.size();
   end

endmodule

`default_nettype wire

[sim/tb_smtp_server_session_fsm.sv]
`default_nettype none

module tb_smtp_server_session_fsm;
   import smtp_pkg::*;
   import smtp_tb_pkg::*;

   localparam int REQ_BITS       = $bits(req_type);
   localparam int RX_HOLD_CYCLES = 80;       // long receiver hold-off
   localparam int CYCLE_LIMIT    = 60000;    // watchdog, far above the slowest legal run
   localparam int SETTLE_CYCLES  = 4;        // latency margin before CSR writes and at the end

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid;
   logic        req_stall;
   req_type     req_item;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_item;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        end_of_run;

   int fail_count;
   int pending_results;
   int results_checked;

   int items_sent   = 0;
   int sessions_run = 0;
   int tx_idle_pct  = 0;     // chance of a gap before a request
   int rx_idle_pct  = 0;     // chance of a stall burst on results
   bit rx_hold_req  = 1'b0;  // asks the receiver for one long hold-off
   int cycle_count  = 0;
   logic [1:0] mode_now;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   smtp_server_session_fsm DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // watches all three ports, predicts and compares
   smtp_session_checker session_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .end_of_run      (end_of_run),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // Result receiver. Random stall bursts, plus one long hold-off counted
   // here so the block's result queue fills and it stalls the request side.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
            rx_hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side. Every task is entered in the time step of a rising edge.
   // valid stays high across back-to-back transfers; it is only dropped
   // for a gap, a drain or the end of stimulus.
   // ---------------------------------------------------------------------
   task automatic send_item(input req_type it);
      if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);   // transfer happens at this edge
      items_sent++;
   endtask

   // Fields that the item kind does not use carry random junk.
   task automatic send_command(input logic [3:0] code, input logic ok);
      req_type it;
      it = REQ_BITS'($urandom);
      it.cmd          = KIND_COMMAND;
      it.command_code = code;
      it.params_ok    = ok;
      send_item(it);
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_type it;
      it = REQ_BITS'($urandom);
      it.cmd          = KIND_BYTE;
      it.payload_byte = b;
      send_item(it);
   endtask

   task automatic send_kind(input logic [2:0] kind);
      req_type it;
      it = REQ_BITS'($urandom);
      it.cmd = kind;
      send_item(it);
   endtask

   task automatic send_store(input logic ok);
      req_type it;
      it = REQ_BITS'($urandom);
      it.cmd      = KIND_STORE;
      it.store_ok = ok;
      send_item(it);
   endtask

   // fully random item: reserved kinds, codes above nine, misplaced items
   task automatic inject_noise();
      req_type junk;
      if ($urandom_range(0, 99) < 6) begin
         junk = REQ_BITS'($urandom);
         send_item(junk);
      end
   endtask

   function automatic logic mostly_one();
      return $urandom_range(0, 9) != 0;
   endfunction

   // body bytes lean toward the terminator characters
   function automatic logic [7:0] body_byte();
      case ($urandom_range(0, 7))
         0, 1:    return CH_CR;
         2:       return CH_LF;
         3:       return CH_DOT;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_terminator();
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(CH_DOT);
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   task automatic send_body(input int len);
      repeat (len) begin
         if ($urandom_range(0, 4) == 0) begin
            // near miss: CR LF . (CR) then something that usually breaks it
            send_byte(CH_CR);
            send_byte(CH_LF);
            send_byte(CH_DOT);
            if ($urandom_range(0, 1)) send_byte(CH_CR);
            send_byte(body_byte());
         end else begin
            send_byte(body_byte());
         end
      end
   endtask

   // One client session: well-formed order with random content (random commands only in
   // dysfunctional mode), some rejected parameters, a stray command now and then, and random noise.
   // The long-hold session keeps a clean order up to its body so the body really streams.
   task automatic run_session(input bit long_hold);
      int body_len;
      sessions_run++;
      send_kind(KIND_OPEN);
      if (mode_now == MODE_DYSFUNCTIONAL) begin
         repeat ($urandom_range(2, 4)) send_command(4'($urandom_range(0, CMD_TOP)), 1'($urandom));
      end else begin
         if (mode_now == MODE_WELCOME)
            send_command($urandom_range(0, 1) ? CMD_EHLO : CMD_HELO, long_hold || mostly_one());
         repeat ($urandom_range(1, 2)) begin
            if (!long_hold) inject_noise();
            send_command(CMD_MAIL, long_hold || mostly_one());
            repeat ($urandom_range(1, 4)) send_command(CMD_RCPT, long_hold || mostly_one());
            if (!long_hold && $urandom_range(0, 7) == 0)
               send_command(4'($urandom_range(CMD_RSET, CMD_TOP)), 1'($urandom));
            send_command(CMD_DATA, 1'($urandom));
            body_len = $urandom_range(0, 10);
            if (long_hold) begin
               rx_hold_req = 1'b1;   // receiver freezes while the body streams in
               body_len = 24;
            end
            send_body(body_len);
            inject_noise();
            send_terminator();
            send_store($urandom_range(0, 3) != 0);
         end
      end
      case ($urandom_range(0, 9))
         0, 1:    send_kind(KIND_LINK_ERROR);
         2:       ;   // leave it open, the next open may be ignored
         default: send_command(CMD_QUIT, 1'($urandom));
      endcase
   endtask

   // Sender pauses until every expected result has been seen.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // registers only change with the block idle
   task automatic apply_settings(input logic [1:0] mode, input logic [7:0] limit);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(CSR_START_MODE, {30'd0, mode});
      csr_write(CSR_RCPT_LIMIT, {24'd0, limit});
      mode_now = mode;
   endtask

   initial begin
      req_valid   = 1'b0;
      req_item    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      end_of_run  = 1'b0;
      mode_now    = MODE_WELCOME;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // -------- directed: command order, replies, matcher corner cases --------
      apply_settings(MODE_WELCOME, 8'd2);
      tx_idle_pct = 20;
      rx_idle_pct = 20;
      send_command(CMD_EHLO, 1'b1);     // command before open: dropped
      send_kind(KIND_OPEN);             // 220 welcome
      send_command(CMD_MAIL, 1'b1);     // out of order: 503
      send_command(CMD_EHLO, 1'b0);     // parameters refused: 455
      send_command(CMD_HELO, 1'b1);
      send_command(CMD_VRFY, 1'b1);
      send_command(CMD_TOP, 1'b0);      // code above nine: 500
      send_command(CMD_MAIL, 1'b1);
      send_command(CMD_RCPT, 1'b1);
      send_command(CMD_RCPT, 1'b1);
      send_command(CMD_RCPT, 1'b1);     // past the limit: 452, count held
      send_command(CMD_DATA, 1'b1);
      send_byte(8'h00);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(CH_DOT);
      send_byte(8'hFF);                 // breaks after the dot: dot and FF released
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(CH_DOT);
      send_byte(CH_CR);
      send_byte(8'h5A);                 // breaks after dot CR: three bytes released
      send_terminator();                // body done
      send_store(1'b0);                 // store failure: 452, back to recipients
      send_command(CMD_RSET, 1'b1);     // clears the count
      send_kind(KIND_LINK_ERROR);       // receive error ends the session

      // -------- random, welcome mode, widest limit, one long receiver hold --------
      // the first session starts from idle, so its long hold really fills the block
      apply_settings(MODE_WELCOME, 8'd255);
      while (items_sent < 130) begin
         // alternate stretches with and without gaps on each side
         tx_idle_pct = (sessions_run % 3 == 0) ? 0 : 25;
         rx_idle_pct = (sessions_run % 4 == 1) ? 0 : 25;
         run_session(sessions_run == 0);
         if (sessions_run % 5 == 0) wait_for_results();
      end

      // -------- random, already greeted, single recipient --------
      apply_settings(MODE_GREETED, 8'd1);
      while (items_sent < 185) begin
         tx_idle_pct = (sessions_run % 2 == 0) ? 30 : 10;
         rx_idle_pct = (sessions_run % 3 == 0) ? 0 : 30;
         run_session(1'b0);
      end

      // -------- random, dysfunctional server --------
      apply_settings(MODE_DYSFUNCTIONAL, 8'd3);
      while (items_sent < 205) run_session(1'b0);

      // -------- tail: default limit, no gaps on either side --------
      apply_settings(MODE_WELCOME, 8'd100);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      while (items_sent < 275) run_session(1'b0);

      wait_for_results();
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      end_of_run <= 1'b1;    // checker flushes anything left over
      @(posedge clock);
      end_of_run <= 1'b0;
      @(negedge clock);

      $display("Covered %0d request transfers in %0d sessions: welcome, greeted and",
               items_sent, sessions_run);
      $display("dysfunctional start modes, recipient limits 1 to 255; %0d results, %0d errors",
               results_checked, fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
